[sv/pls_pkg.sv]
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types, codes and reset values for the pump link supervisor.
// ----------------------------------------------------------------------------
package pls_pkg;

  // Default values of the top-level parameters.
  localparam int VOTE_WINDOW_DEF = 10;
  localparam int RUN_WIDTH_DEF   = 16;

  // A vote count must exceed this to switch the pump.
  localparam int VOTE_MAJORITY = 7;

  // Event codes carried by func.
  localparam logic [2:0] FN_SERIAL_CMD     = 3'd0;
  localparam logic [2:0] FN_SERIAL_TIMEOUT = 3'd1;
  localparam logic [2:0] FN_PWM_SAMPLE     = 3'd2;
  localparam logic [2:0] FN_PWM_TIMEOUT    = 3'd3;
  localparam logic [2:0] FN_SENSE_TICK     = 3'd4;

  // Serial command bytes that switch the pump.
  localparam logic [7:0] CMD_OFF = 8'd0;
  localparam logic [7:0] CMD_ON  = 8'd1;

  // Alert codes.
  localparam logic [2:0] AL_MUTE        = 3'd0;
  localparam logic [2:0] AL_POWER_ON    = 3'd1;
  localparam logic [2:0] AL_NO_SERIAL   = 3'd2;
  localparam logic [2:0] AL_NO_PERMIT   = 3'd3;
  localparam logic [2:0] AL_LOST_PWM    = 3'd4;
  localparam logic [2:0] AL_LOST_SERIAL = 3'd5;
  localparam logic [2:0] AL_PWM_OK      = 3'd6;
  localparam logic [2:0] AL_SERIAL_OK   = 3'd7;

  // Configuration register indexes.
  localparam logic [2:0] REG_PWM_LOW     = 3'd0;
  localparam logic [2:0] REG_PWM_HIGH    = 3'd1;
  localparam logic [2:0] REG_CURRENT     = 3'd2;
  localparam logic [2:0] REG_PERSIST     = 3'd3;
  localparam logic [2:0] REG_START_DELAY = 3'd4;
  localparam logic [2:0] REG_ON_LEVEL    = 3'd5;
  localparam logic [2:0] REG_SERIAL      = 3'd6;
  localparam logic [2:0] REG_PERMITTED   = 3'd7;

  // Configuration register reset values.
  localparam logic [15:0] PWM_LOW_RST     = 16'd1300;
  localparam logic [15:0] PWM_HIGH_RST    = 16'd1700;
  localparam logic [15:0] CURRENT_RST     = 16'd500;
  localparam logic [15:0] PERSIST_RST     = 16'd50;
  localparam logic [15:0] START_DELAY_RST = 16'd100;
  localparam logic [15:0] ON_LEVEL_RST    = 16'd1000;

  typedef struct packed {
    logic [15:0] pwm_low_threshold;
    logic [15:0] pwm_high_threshold;
    logic [15:0] current_threshold;
    logic [15:0] persist_count;
    logic [15:0] start_delay_ticks;
    logic [15:0] pump_on_level;
    logic        serial_saved;
    logic        permitted;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  command_code;
    logic [31:0] target_voltage;
    logic [15:0] pulse_width;
    logic [15:0] pump_current;
  } item_t;

  typedef struct packed {
    logic [15:0] drive_level;
    logic        remote_online;
    logic        pwm_online;
    logic        tank_empty;
    logic [2:0]  alert_code;
    logic [31:0] target_out;
  } result_t;

endpackage

[sv/pls_in_reg.sv]
// ----------------------------------------------------------------------------
// pls_in_reg
// Input register: captures one event transaction and holds it until the
// supervisor core takes it.
// ----------------------------------------------------------------------------
module pls_in_reg import pls_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [7:0]  command_code,
  input  logic [31:0] target_voltage,
  input  logic [15:0] pulse_width,
  input  logic [15:0] pump_current,
  input  logic        take,
  output logic        held_valid,
  output item_t       held
);

  // The register frees up in the same cycle that its content is taken.
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      held.func           <= func;
      held.command_code   <= command_code;
      held.target_voltage <= target_voltage;
      held.pulse_width    <= pulse_width;
      held.pump_current   <= pump_current;
    end
  end

endmodule

[sv/pls_core.sv]
// ----------------------------------------------------------------------------
// pls_core
// Supervisor state and its update for one event, with the
// status that results from it.
// ----------------------------------------------------------------------------
module pls_core import pls_pkg::*; #(
  parameter int VOTE_WINDOW = VOTE_WINDOW_DEF,
  parameter int RUN_WIDTH   = RUN_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int CNT_W = $clog2(VOTE_WINDOW + 1);
  localparam int CMP_W = (RUN_WIDTH > 16) ? RUN_WIDTH : 16;
  localparam logic [RUN_WIDTH-1:0] RUN_MAX = {RUN_WIDTH{1'b1}};

  logic [CNT_W-1:0]     window_count, window_count_next;
  logic [CNT_W-1:0]     off_votes, off_votes_next;
  logic [CNT_W-1:0]     on_votes, on_votes_next;
  logic                 remote_seen, remote_seen_next;
  logic                 pwm_seen, pwm_seen_next;
  logic                 pump_is_on, pump_is_on_next;
  logic                 delay_armed, delay_armed_next;
  logic [15:0]          delay_left, delay_left_next;
  logic [RUN_WIDTH-1:0] high_run, high_run_next;
  logic [RUN_WIDTH-1:0] low_run, low_run_next;
  logic                 low_confirmed, low_confirmed_next;
  logic                 empty_flag, empty_flag_next;
  logic [2:0]           alert_state, alert_state_next;
  logic [31:0]          target_store, target_store_next;
  logic                 blocked;

  assign blocked = !cfg.serial_saved || !cfg.permitted;

  always_comb begin
    window_count_next  = window_count;
    off_votes_next     = off_votes;
    on_votes_next      = on_votes;
    remote_seen_next   = remote_seen;
    pwm_seen_next      = pwm_seen;
    pump_is_on_next    = pump_is_on;
    delay_armed_next   = delay_armed;
    delay_left_next    = delay_left;
    high_run_next      = high_run;
    low_run_next       = low_run;
    low_confirmed_next = low_confirmed;
    empty_flag_next    = empty_flag;
    alert_state_next   = alert_state;
    target_store_next  = target_store;

    unique case (item.func)
      FN_SERIAL_CMD: begin
        if (!blocked) begin
          if (item.command_code == CMD_ON) begin
            if (!delay_armed) begin
              delay_armed_next = 1'b1;
              delay_left_next  = cfg.start_delay_ticks;
            end
            pump_is_on_next  = 1'b1;
            remote_seen_next = 1'b1;
          end else if (item.command_code == CMD_OFF) begin
            delay_armed_next = 1'b0;
            delay_left_next  = '0;
            pump_is_on_next  = 1'b0;
            remote_seen_next = 1'b1;
          end
          target_store_next = item.target_voltage;
          alert_state_next  = AL_SERIAL_OK;
        end
      end
      FN_SERIAL_TIMEOUT: begin
        if (!blocked) begin
          delay_armed_next = 1'b0;
          delay_left_next  = '0;
          remote_seen_next = 1'b0;
          if (!pwm_seen) begin
            pump_is_on_next = 1'b0;
          end
          if (alert_state != AL_PWM_OK) begin
            alert_state_next = AL_LOST_SERIAL;
          end
        end
      end
      FN_PWM_SAMPLE: begin
        if (!blocked && !remote_seen) begin
          if (32'(window_count) < VOTE_WINDOW) begin
            window_count_next = window_count + CNT_W'(1);
            if (item.pulse_width < cfg.pwm_low_threshold) begin
              off_votes_next = off_votes + CNT_W'(1);
            end else if (item.pulse_width > cfg.pwm_high_threshold) begin
              on_votes_next = on_votes + CNT_W'(1);
            end
          end else begin
            // Window closed: this sample only evaluates; off wins over on.
            window_count_next = '0;
            if (32'(off_votes) > VOTE_MAJORITY) begin
              pump_is_on_next = 1'b0;
            end else if (32'(on_votes) > VOTE_MAJORITY) begin
              pump_is_on_next = 1'b1;
            end
            off_votes_next = '0;
            on_votes_next  = '0;
          end
          pwm_seen_next    = 1'b1;
          alert_state_next = AL_PWM_OK;
        end
      end
      FN_PWM_TIMEOUT: begin
        if (!blocked && !remote_seen) begin
          pwm_seen_next    = 1'b0;
          pump_is_on_next  = 1'b0;
          alert_state_next = AL_LOST_PWM;
        end
      end
      FN_SENSE_TICK: begin
        if (delay_left != '0) begin
          delay_left_next    = delay_left - 16'd1;
          high_run_next      = '0;
          low_run_next       = '0;
          low_confirmed_next = 1'b0;
        end else begin
          if (item.pump_current > cfg.current_threshold) begin
            low_run_next = '0;
            if (high_run != RUN_MAX) begin
              high_run_next = high_run + RUN_WIDTH'(1);
            end
            if (CMP_W'(high_run_next) > CMP_W'(cfg.persist_count)) begin
              low_confirmed_next = 1'b0;
            end
          end else begin
            high_run_next = '0;
            if (low_run != RUN_MAX) begin
              low_run_next = low_run + RUN_WIDTH'(1);
            end
            if (CMP_W'(low_run_next) > CMP_W'(cfg.persist_count)) begin
              low_confirmed_next = 1'b1;
            end
          end
          empty_flag_next = pump_is_on && low_confirmed_next;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count  <= '0;
      off_votes     <= '0;
      on_votes      <= '0;
      remote_seen   <= 1'b0;
      pwm_seen      <= 1'b0;
      pump_is_on    <= 1'b0;
      delay_armed   <= 1'b0;
      delay_left    <= '0;
      high_run      <= '0;
      low_run       <= '0;
      low_confirmed <= 1'b0;
      empty_flag    <= 1'b0;
      alert_state   <= AL_POWER_ON;
      target_store  <= '0;
    end else if (en) begin
      window_count  <= window_count_next;
      off_votes     <= off_votes_next;
      on_votes      <= on_votes_next;
      remote_seen   <= remote_seen_next;
      pwm_seen      <= pwm_seen_next;
      pump_is_on    <= pump_is_on_next;
      delay_armed   <= delay_armed_next;
      delay_left    <= delay_left_next;
      high_run      <= high_run_next;
      low_run       <= low_run_next;
      low_confirmed <= low_confirmed_next;
      empty_flag    <= empty_flag_next;
      alert_state   <= alert_state_next;
      target_store  <= target_store_next;
    end
  end

  // Status after the event; a missing serial number or permit overrides
  // the stored alert.
  always_comb begin
    result.drive_level   = pump_is_on_next ? cfg.pump_on_level : 16'd0;
    result.remote_online = remote_seen_next;
    result.pwm_online    = pwm_seen_next;
    result.tank_empty    = empty_flag_next;
    if (!cfg.serial_saved) begin
      result.alert_code = AL_NO_SERIAL;
    end else if (!cfg.permitted) begin
      result.alert_code = AL_NO_PERMIT;
    end else begin
      result.alert_code = alert_state_next;
    end
    result.target_out = target_store_next;
  end

endmodule

[sv/pump_link_supervisor.sv]
// ----------------------------------------------------------------------------
// pump_link_supervisor
// Event-driven pump supervisor: serial control, PWM voting fallback and
// empty-tank detection from pump current.
// ----------------------------------------------------------------------------
// Each input transaction is one event (serial command, serial timeout, PWM
// sample, PWM timeout or sense tick) and produces exactly one output
// transaction with the pump status after that event. The block sustains one
// transaction per clock while the output is not stalled: an event waits in
// the input register, and as it moves on into the core, the supervisor state
// is updated and the status is captured in the output register at the same
// edge. The single state-update stage is what sets the rate. A stalled output
// stops the pipe only once both the input and output registers are full.
// Configuration registers are written through cfg_we / cfg_index / cfg_data
// at any edge and must only change while no transaction is in flight.
// ----------------------------------------------------------------------------
module pump_link_supervisor import pls_pkg::*; #(
  parameter int VOTE_WINDOW = VOTE_WINDOW_DEF,
  parameter int RUN_WIDTH   = RUN_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Event channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [7:0]  command_code,
  input  logic [31:0] target_voltage,
  input  logic [15:0] pulse_width,
  input  logic [15:0] pump_current,
  // Status channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] drive_level,
  output logic        remote_online,
  output logic        pwm_online,
  output logic        tank_empty,
  output logic [2:0]  alert_code,
  output logic [31:0] target_out
);

  cfg_t    cfg;
  item_t   held;
  logic    held_valid;
  logic    advance;
  result_t result;
  result_t res;

  // The held event moves into the core when the output register is empty
  // or is being emptied in this cycle.
  assign advance = held_valid && (!out_valid || out_ready);

  // Configuration registers. Single-bit registers keep the low data bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pwm_low_threshold  <= PWM_LOW_RST;
      cfg.pwm_high_threshold <= PWM_HIGH_RST;
      cfg.current_threshold  <= CURRENT_RST;
      cfg.persist_count      <= PERSIST_RST;
      cfg.start_delay_ticks  <= START_DELAY_RST;
      cfg.pump_on_level      <= ON_LEVEL_RST;
      cfg.serial_saved       <= 1'b1;
      cfg.permitted          <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PWM_LOW:     cfg.pwm_low_threshold  <= cfg_data;
        REG_PWM_HIGH:    cfg.pwm_high_threshold <= cfg_data;
        REG_CURRENT:     cfg.current_threshold  <= cfg_data;
        REG_PERSIST:     cfg.persist_count      <= cfg_data;
        REG_START_DELAY: cfg.start_delay_ticks  <= cfg_data;
        REG_ON_LEVEL:    cfg.pump_on_level      <= cfg_data;
        REG_SERIAL:      cfg.serial_saved       <= cfg_data[0];
        REG_PERMITTED:   cfg.permitted          <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  pls_in_reg u_in_reg (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .command_code   (command_code),
    .target_voltage (target_voltage),
    .pulse_width    (pulse_width),
    .pump_current   (pump_current),
    .take           (advance),
    .held_valid     (held_valid),
    .held           (held)
  );

  pls_core #(
    .VOTE_WINDOW (VOTE_WINDOW),
    .RUN_WIDTH   (RUN_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (held),
    .cfg    (cfg),
    .result (result)
  );

  // Output register: holds the status until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      res <= result;
    end
  end

  assign drive_level   = res.drive_level;
  assign remote_online = res.remote_online;
  assign pwm_online    = res.pwm_online;
  assign tank_empty    = res.tank_empty;
  assign alert_code    = res.alert_code;
  assign target_out    = res.target_out;

endmodule

[test/pump_link_supervisor_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pump_link_supervisor_test
// Self-checking bench for the pump link supervisor. Events are pushed through
// the valid/ready event channel, and a cycle-free model of the supervisor
// predicts the status for each one. The bench walks through several register
// settings: reset values, narrow thresholds, both extremes and blocked
// control. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module pump_link_supervisor_test;
  import pls_pkg::*;

  // The spare event codes only report the status.
  localparam logic [2:0] FN_SPARE_A = 3'd5;
  localparam logic [2:0] FN_SPARE_B = 3'd6;
  localparam logic [2:0] FN_SPARE_C = 3'd7;

  localparam int          WINDOW         = VOTE_WINDOW_DEF;
  localparam logic [15:0] RUN_MAX        = {RUN_WIDTH_DEF{1'b1}};
  // The pipe is two registers deep, so a handful of cycles covers it.
  localparam int          SETTLE_CYCLES  = 8;
  // The slowest legal transaction spacing is the longest input gap plus the
  // longest output stall plus the pipe; a register-write pause adds more.
  localparam int          WATCHDOG_LIMIT = 2000;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        cfg_we         = 1'b0;
  logic [2:0]  cfg_index      = REG_PWM_LOW;
  logic [15:0] cfg_data       = '0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [2:0]  func           = FN_SERIAL_CMD;
  logic [7:0]  command_code   = '0;
  logic [31:0] target_voltage = '0;
  logic [15:0] pulse_width    = '0;
  logic [15:0] pump_current   = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [15:0] drive_level;
  logic        remote_online;
  logic        pwm_online;
  logic        tank_empty;
  logic [2:0]  alert_code;
  logic [31:0] target_out;

  pump_link_supervisor u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .command_code   (command_code),
    .target_voltage (target_voltage),
    .pulse_width    (pulse_width),
    .pump_current   (pump_current),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .drive_level    (drive_level),
    .remote_online  (remote_online),
    .pwm_online     (pwm_online),
    .tank_empty     (tank_empty),
    .alert_code     (alert_code),
    .target_out     (target_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Events waiting to be driven, and statuses predicted but not yet seen.
  item_t   event_queue[$];
  result_t status_due[$];

  // Shadow of the configuration registers and of the supervisor state.
  cfg_t        cfg_model;
  logic [3:0]  win_fill, off_tally, on_tally;
  logic        remote_up, pwm_up, pump_on, start_armed;
  logic [15:0] start_ticks_left, loaded_streak, light_streak;
  logic        light_confirmed, tank_dry;
  logic [2:0]  alert_latch;
  logic [31:0] target_latch;

  // Idle pacing for each side: a stretch of items shares one style.
  // Style 0 never idles, style 1 draws an idle spell for every item, and
  // style 2 idles only now and then. The steady flag holds both sides busy
  // during the back-to-back runs.
  logic  steady = 1'b0;
  int    in_gap = 0, in_left = 0, in_style = 0;
  int    out_hold = 0, out_left = 0, out_style = 0;
  item_t on_wire;

  int      error_count = 0;
  int      events_taken = 0;
  int      statuses_seen = 0;
  int      driven_reports = 0;
  int      dry_reports = 0;
  int      settings_used = 1;
  int      quiet_cycles = 0;
  result_t status_want;

  task automatic reset_supervisor();
    cfg_model.pwm_low_threshold  = PWM_LOW_RST;
    cfg_model.pwm_high_threshold = PWM_HIGH_RST;
    cfg_model.current_threshold  = CURRENT_RST;
    cfg_model.persist_count      = PERSIST_RST;
    cfg_model.start_delay_ticks  = START_DELAY_RST;
    cfg_model.pump_on_level      = ON_LEVEL_RST;
    cfg_model.serial_saved       = 1'b1;
    cfg_model.permitted          = 1'b1;
    win_fill         = '0;
    off_tally        = '0;
    on_tally         = '0;
    remote_up        = 1'b0;
    pwm_up           = 1'b0;
    pump_on          = 1'b0;
    start_armed      = 1'b0;
    start_ticks_left = '0;
    loaded_streak    = '0;
    light_streak     = '0;
    light_confirmed  = 1'b0;
    tank_dry         = 1'b0;
    alert_latch      = AL_POWER_ON;
    target_latch     = '0;
  endtask

  // Advances the shadow supervisor by one event and queues the status that
  // the block must report for it.
  task automatic step_supervisor(input item_t ev);
    logic    locked;
    result_t st;
    locked = !cfg_model.serial_saved || !cfg_model.permitted;
    if (!locked && ev.func == FN_SERIAL_CMD) begin
      // Only on and off switch the pump; any code refreshes the target.
      if (ev.command_code == CMD_ON) begin
        if (!start_armed) begin
          start_armed      = 1'b1;
          start_ticks_left = cfg_model.start_delay_ticks;
        end
        pump_on   = 1'b1;
        remote_up = 1'b1;
      end else if (ev.command_code == CMD_OFF) begin
        start_armed      = 1'b0;
        start_ticks_left = '0;
        pump_on          = 1'b0;
        remote_up        = 1'b1;
      end
      target_latch = ev.target_voltage;
      alert_latch  = AL_SERIAL_OK;
    end else if (!locked && ev.func == FN_SERIAL_TIMEOUT) begin
      start_armed      = 1'b0;
      start_ticks_left = '0;
      remote_up        = 1'b0;
      if (!pwm_up) pump_on = 1'b0;
      if (alert_latch != AL_PWM_OK) alert_latch = AL_LOST_SERIAL;
    end else if (!locked && ev.func == FN_PWM_SAMPLE && !remote_up) begin
      // The sample after a full window votes for nothing; it settles the
      // window instead, and off beats on.
      if (win_fill < WINDOW) begin
        win_fill++;
        if (ev.pulse_width < cfg_model.pwm_low_threshold) off_tally++;
        else if (ev.pulse_width > cfg_model.pwm_high_threshold) on_tally++;
      end else begin
        win_fill = '0;
        if (off_tally > VOTE_MAJORITY) pump_on = 1'b0;
        else if (on_tally > VOTE_MAJORITY) pump_on = 1'b1;
        off_tally = '0;
        on_tally  = '0;
      end
      pwm_up      = 1'b1;
      alert_latch = AL_PWM_OK;
    end else if (!locked && ev.func == FN_PWM_TIMEOUT && !remote_up) begin
      pwm_up      = 1'b0;
      pump_on     = 1'b0;
      alert_latch = AL_LOST_PWM;
    end else if (ev.func == FN_SENSE_TICK) begin
      // Sense ticks run even while control is blocked.
      if (start_ticks_left != 0) begin
        start_ticks_left--;
        loaded_streak   = '0;
        light_streak    = '0;
        light_confirmed = 1'b0;
      end else begin
        if (ev.pump_current > cfg_model.current_threshold) begin
          light_streak = '0;
          if (loaded_streak != RUN_MAX) loaded_streak++;
          if (loaded_streak > cfg_model.persist_count) light_confirmed = 1'b0;
        end else begin
          loaded_streak = '0;
          if (light_streak != RUN_MAX) light_streak++;
          if (light_streak > cfg_model.persist_count) light_confirmed = 1'b1;
        end
        tank_dry = pump_on && light_confirmed;
      end
    end

    st.drive_level   = pump_on ? cfg_model.pump_on_level : '0;
    st.remote_online = remote_up;
    st.pwm_online    = pwm_up;
    st.tank_empty    = tank_dry;
    if (!cfg_model.serial_saved) st.alert_code = AL_NO_SERIAL;
    else if (!cfg_model.permitted) st.alert_code = AL_NO_PERMIT;
    else st.alert_code = alert_latch;
    st.target_out = target_latch;
    status_due.push_back(st);
  endtask

  function automatic int draw_wait(input int style);
    case (style)
      0:       return 0;
      1:       return $urandom_range(0, 19);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    endcase
  endfunction

  // Event driver. A new event goes out when the wire is empty or its
  // current event is taken at this edge, so valid is written once per edge.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        step_supervisor(on_wire);
        events_taken++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (event_queue.size() != 0) begin
          on_wire = event_queue.pop_front();
          func           <= on_wire.func;
          command_code   <= on_wire.command_code;
          target_voltage <= on_wire.target_voltage;
          pulse_width    <= on_wire.pulse_width;
          pump_current   <= on_wire.pump_current;
          in_valid       <= 1'b1;
          if (in_left == 0) begin
            in_left  = $urandom_range(10, 60);
            in_style = $urandom_range(0, 2);
          end
          in_left--;
          in_gap = steady ? 0 : draw_wait(in_style);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Status monitor. Each status transaction is matched against the oldest
  // prediction; ready then drops for a drawn number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        statuses_seen++;
        if (drive_level != 0) driven_reports++;
        if (tank_empty) dry_reports++;
        if (status_due.size() == 0) begin
          $error("status transaction with no event outstanding: drive_level 0x%0h",
                 drive_level);
          error_count++;
        end else begin
          status_want = status_due.pop_front();
          check_field("drive_level", status_want.drive_level, drive_level);
          check_field("remote_online", status_want.remote_online, remote_online);
          check_field("pwm_online", status_want.pwm_online, pwm_online);
          check_field("tank_empty", status_want.tank_empty, tank_empty);
          check_field("alert_code", status_want.alert_code, alert_code);
          check_field("target_out", status_want.target_out, target_out);
        end
        if (out_left == 0) begin
          out_left  = $urandom_range(10, 60);
          out_style = $urandom_range(0, 2);
        end
        out_left--;
        out_hold = steady ? 0 : draw_wait(out_style);
      end
      if (out_hold > 0) begin
        out_ready <= 1'b0;
        out_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: any transaction on either channel counts as progress.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("pump_link_supervisor_test: errors");
          $finish;
        end
      end
    end
  end

  // Random values for every field, so that fields the event does not use
  // still see all their bits toggle.
  function automatic item_t blank_event(input logic [2:0] f);
    item_t ev;
    ev.func           = f;
    ev.command_code   = 8'($urandom_range(0, 255));
    ev.target_voltage = $urandom;
    ev.pulse_width    = 16'($urandom_range(0, 65535));
    ev.pump_current   = 16'($urandom_range(0, 65535));
    return ev;
  endfunction

  task automatic push_event(input logic [2:0] f, input logic [7:0] code,
                            input logic [31:0] target, input logic [15:0] width,
                            input logic [15:0] current);
    item_t ev;
    ev.func           = f;
    ev.command_code   = code;
    ev.target_voltage = target;
    ev.pulse_width    = width;
    ev.pump_current   = current;
    event_queue.push_back(ev);
  endtask

  function automatic logic [7:0] draw_command();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return CMD_ON;
    if (pick < 8) return CMD_OFF;
    return 8'($urandom_range(2, 255));
  endfunction

  function automatic logic [15:0] draw_under(input logic [15:0] lim);
    return (lim == 0) ? 16'd0 : 16'($urandom_range(0, lim - 1));
  endfunction

  function automatic logic [15:0] draw_at_most(input logic [15:0] lim);
    return 16'($urandom_range(0, lim));
  endfunction

  function automatic logic [15:0] draw_over(input logic [15:0] lim);
    return (lim == 16'hFFFF) ? 16'hFFFF : 16'($urandom_range(lim + 1, 65535));
  endfunction

  function automatic logic [15:0] draw_between(input logic [15:0] lo,
                                               input logic [15:0] hi);
    return 16'((lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(hi, lo));
  endfunction

  // A serial session: a command (mostly a start), then sense ticks in runs of
  // light and heavy current that can pass the start delay and confirm
  // a level, with the odd stray control event, closed by a stop or a timeout.
  task automatic queue_serial_session();
    item_t ev;
    int    span, ticks, run_left, hold_cap;
    logic  light;
    ev = blank_event(FN_SERIAL_CMD);
    ev.command_code = draw_command();
    event_queue.push_back(ev);
    hold_cap = (cfg_model.persist_count > 60) ? 60 : cfg_model.persist_count;
    span = (cfg_model.start_delay_ticks > 120) ? 120 : cfg_model.start_delay_ticks;
    span = span + 3 * (hold_cap + 4) + 8;
    if (span > 200) span = 200;
    ticks = $urandom_range(4, span);
    run_left = 0;
    light = 1'b0;
    repeat (ticks) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, hold_cap + 4);
        light = ($urandom_range(0, 9) < 6);
      end
      run_left--;
      if ($urandom_range(0, 14) == 0) begin
        ev = blank_event(3'($urandom_range(0, 3)));
        ev.command_code = draw_command();
        event_queue.push_back(ev);
      end
      ev = blank_event(FN_SENSE_TICK);
      if ($urandom_range(0, 19) != 0)
        ev.pump_current = light ? draw_at_most(cfg_model.current_threshold)
                                : draw_over(cfg_model.current_threshold);
      event_queue.push_back(ev);
    end
    if ($urandom_range(0, 1) == 0) begin
      ev = blank_event(FN_SERIAL_CMD);
      ev.command_code = CMD_OFF;
      event_queue.push_back(ev);
    end else begin
      event_queue.push_back(blank_event(FN_SERIAL_TIMEOUT));
    end
  endtask

  // A PWM fallback session: the remote drops out and the samples lean low,
  // high or in between; a low or high lean usually carries a window's majority.
  task automatic queue_pwm_session();
    item_t ev;
    int    lean;
    event_queue.push_back(blank_event(FN_SERIAL_TIMEOUT));
    lean = $urandom_range(0, 2);
    repeat ($urandom_range(5, 35)) begin
      ev = blank_event(FN_PWM_SAMPLE);
      if ($urandom_range(0, 9) != 0) begin
        case (lean)
          0:       ev.pulse_width = draw_under(cfg_model.pwm_low_threshold);
          1:       ev.pulse_width = draw_over(cfg_model.pwm_high_threshold);
          default: ev.pulse_width = draw_between(cfg_model.pwm_low_threshold,
                                                 cfg_model.pwm_high_threshold);
        endcase
      end
      event_queue.push_back(ev);
      if ($urandom_range(0, 5) == 0) event_queue.push_back(blank_event(FN_SENSE_TICK));
    end
    if ($urandom_range(0, 3) == 0) event_queue.push_back(blank_event(FN_PWM_TIMEOUT));
  endtask

  task automatic queue_traffic(input int goal);
    int base;
    base = event_queue.size();
    while (event_queue.size() - base < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: queue_serial_session();
        4, 5, 6:    queue_pwm_session();
        default: begin
          repeat ($urandom_range(1, 5))
            event_queue.push_back(blank_event(3'($urandom_range(0, 7))));
        end
      endcase
    end
  endtask

  // Sampled at the falling edge so that every update of the rising edge has
  // landed before the wire and the queues are looked at.
  task automatic drain();
    do @(negedge clk);
    while (event_queue.size() != 0 || in_valid || status_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t make_setting(input logic [15:0] low, input logic [15:0] high,
                                        input logic [15:0] current,
                                        input logic [15:0] persist,
                                        input logic [15:0] delay,
                                        input logic [15:0] level,
                                        input logic saved, input logic granted);
    cfg_t c;
    c.pwm_low_threshold  = low;
    c.pwm_high_threshold = high;
    c.current_threshold  = current;
    c.persist_count      = persist;
    c.start_delay_ticks  = delay;
    c.pump_on_level      = level;
    c.serial_saved       = saved;
    c.permitted          = granted;
    return c;
  endfunction

  // Only called with the pipe empty, so the shadow can switch at once.
  task automatic apply_setting(input cfg_t setting);
    write_reg(REG_PWM_LOW, setting.pwm_low_threshold);
    write_reg(REG_PWM_HIGH, setting.pwm_high_threshold);
    write_reg(REG_CURRENT, setting.current_threshold);
    write_reg(REG_PERSIST, setting.persist_count);
    write_reg(REG_START_DELAY, setting.start_delay_ticks);
    write_reg(REG_ON_LEVEL, setting.pump_on_level);
    write_reg(REG_SERIAL, {15'd0, setting.serial_saved});
    write_reg(REG_PERMITTED, {15'd0, setting.permitted});
    cfg_model = setting;
    settings_used++;
  endtask

  initial begin
    reset_supervisor();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed opening at the reset values. The power-on status comes first,
    // then PWM fallback from power-up, both timeouts, a start and a repeated
    // start, a code that neither starts nor stops, PWM events that must be
    // ignored while the remote is online, a stop, and a window of samples
    // sitting on both sides of each threshold. The spare event codes are
    // spread through it.
    push_event(FN_SENSE_TICK, 8'h00, 32'h0000_0000, 16'h0000, 16'h0000);
    push_event(FN_SPARE_A, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    push_event(FN_PWM_SAMPLE, 8'h00, 32'h0000_0000, 16'h0000, 16'h0000);
    push_event(FN_PWM_TIMEOUT, 8'h00, 32'h0000_0000, 16'h0000, 16'h0000);
    push_event(FN_SERIAL_TIMEOUT, 8'h00, 32'h0000_0000, 16'h0000, 16'h0000);
    push_event(FN_SERIAL_CMD, CMD_ON, 32'hFFFF_FFFF, 16'h0000, 16'h0000);
    push_event(FN_SERIAL_CMD, CMD_ON, 32'h0000_0000, 16'h0000, 16'h0000);
    push_event(FN_SENSE_TICK, 8'h00, 32'h0000_0000, 16'h0000, 16'hFFFF);
    push_event(FN_SERIAL_CMD, 8'hFF, 32'hA5A5_5A5A, 16'h0000, 16'h0000);
    push_event(FN_PWM_SAMPLE, 8'h00, 32'h0000_0000, 16'hFFFF, 16'h0000);
    push_event(FN_PWM_TIMEOUT, 8'h00, 32'h0000_0000, 16'h0000, 16'h0000);
    push_event(FN_SPARE_B, 8'h00, 32'h0000_0000, 16'h0000, 16'h0000);
    push_event(FN_SERIAL_CMD, CMD_OFF, 32'h8000_0001, 16'h0000, 16'h0000);
    push_event(FN_SERIAL_TIMEOUT, 8'h00, 32'h0000_0000, 16'h0000, 16'h0000);
    push_event(FN_PWM_SAMPLE, 8'h00, 32'h0, PWM_LOW_RST - 16'd1, 16'h0000);
    push_event(FN_PWM_SAMPLE, 8'h00, 32'h0, PWM_LOW_RST, 16'h0000);
    push_event(FN_PWM_SAMPLE, 8'h00, 32'h0, PWM_HIGH_RST, 16'h0000);
    push_event(FN_PWM_SAMPLE, 8'h00, 32'h0, PWM_HIGH_RST + 16'd1, 16'h0000);
    repeat (6) push_event(FN_PWM_SAMPLE, 8'h00, 32'h0, 16'h0000, 16'h0000);
    push_event(FN_PWM_SAMPLE, 8'h00, 32'h0, 16'hFFFF, 16'h0000);
    push_event(FN_SPARE_C, 8'h00, 32'h0000_0000, 16'h0000, 16'h0000);
    queue_traffic(130);
    drain();

    // Short delay and persistence so that empty-tank reports come often.
    apply_setting(make_setting(16'd1300, 16'd1700, 16'd500, 16'd3, 16'd2,
                               16'hFFFF, 1'b1, 1'b1));
    queue_traffic(120);
    drain();

    // Low extremes: every nonzero current is a load and one light sample
    // already confirms.
    apply_setting(make_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                               16'h0000, 1'b1, 1'b1));
    queue_traffic(80);
    drain();

    // High extremes. With the longest persistence no run is long enough to
    // confirm, and a heavy run and a light run are driven back to back with
    // no idling.
    apply_setting(make_setting(16'hFFFF, 16'h0000, 16'h7FFF, 16'hFFFF, 16'h0000,
                               16'h0001, 1'b1, 1'b1));
    steady = 1'b1;
    push_event(FN_SERIAL_CMD, CMD_ON, 32'h1234_5678, 16'h0000, 16'h0000);
    repeat (40) push_event(FN_SENSE_TICK, 8'h00, 32'h0, 16'h0000, 16'hFFFF);
    repeat (40) push_event(FN_SENSE_TICK, 8'h00, 32'h0, 16'h0000, 16'h0000);
    drain();
    steady = 1'b0;
    queue_traffic(50);
    drain();

    // Blocked control: no serial number, then no permit, then neither.
    apply_setting(make_setting(16'd1000, 16'd2000, 16'd300, 16'd5, 16'hFFFF,
                               16'd700, 1'b0, 1'b1));
    queue_traffic(60);
    drain();
    apply_setting(make_setting(16'd1000, 16'd2000, 16'd300, 16'd5, 16'd3,
                               16'd700, 1'b1, 1'b0));
    queue_traffic(40);
    drain();
    apply_setting(make_setting(16'd1000, 16'd2000, 16'd300, 16'd5, 16'd3,
                               16'd700, 1'b0, 1'b0));
    queue_traffic(30);
    drain();

    // Control restored, with both PWM thresholds on the same value.
    apply_setting(make_setting(16'd1500, 16'd1500, 16'd1000, 16'd8, 16'd6,
                               16'd4321, 1'b1, 1'b1));
    queue_traffic(100);
    drain();

    $display("run covered %0d events under %0d register settings, %0d statuses checked",
             events_taken, settings_used, statuses_seen);
    $display("statuses with the pump driven: %0d, with the tank reported empty: %0d",
             driven_reports, dry_reports);
    if (error_count == 0) begin
      $display("pump_link_supervisor_test: clean");
    end else begin
      $display("pump_link_supervisor_test: errors");
    end
    $finish;
  end

endmodule

[sim.f]
sv/pls_pkg.sv
sv/pls_in_reg.sv
sv/pls_core.sv
sv/pump_link_supervisor.sv
test/pump_link_supervisor_test.sv
